/* rtl/mexp_pkg.sv */
// shared constants for the modular exponentiation block
`default_nettype none
package mexp_pkg;
	// default operand and exponent widths
	localparam int OPERAND_WIDTH = 31;
	localparam int EXP_WIDTH     = 32;
	// modulus value after reset
	localparam int MODULUS_RESET = 17;
endpackage
`default_nettype wire

/* rtl/modular_exponentiation.sv */
// modular exponentiation top level: square and multiply over a shared modular multiply step
// one bit of the multiplier per cycle passes through the single double-add-reduce unit;
//   a stalled output register delays the result by its wait
// throughput: one item at a time; at the next accept the previous result may still wait in the
//   output register
// reset: arst_n clears the sequencer and the output valid, and sets the modulus to 17
`default_nettype none
module modular_exponentiation #(
	parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH,
	parameter int EXP_WIDTH     = mexp_pkg::EXP_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration: modulus register
	input  wire logic                     modulus_wen,
	input  wire logic [OPERAND_WIDTH-1:0] modulus_wdata,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [OPERAND_WIDTH-1:0] base,
	input  wire logic [EXP_WIDTH-1:0]     exponent,
	// output channel
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [OPERAND_WIDTH-1:0]      remainder
);

	localparam int W  = OPERAND_WIDTH;
	localparam int CW = $clog2(OPERAND_WIDTH);
	localparam int EW = $clog2(EXP_WIDTH);

	// sequencer state codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_SQUARE = 3'd2;
	localparam logic [2:0] ST_MULT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]           state_q;
	logic [W-1:0]         modulus_q;
	logic [CW-1:0]        cnt_q;      // multiplier bit position within one pass
	logic [EW-1:0]        ecnt_q;     // exponent bit position
	logic                 out_valid_q;
	logic [W-1:0]         remainder_q;

	// datapath registers, no reset needed
	logic [W-1:0]         part_q;     // running partial of the modular multiply
	logic [W-1:0]         op_a_q;     // multiplicand
	logic [W-1:0]         op_b_q;     // multiplier, scanned from its top bit
	logic [W-1:0]         base_q;     // base reduced modulo the modulus
	logic [W-1:0]         res_q;      // running power
	logic [EXP_WIDTH-1:0] exp_q;      // exponent, scanned from its top bit

	// shared step: part = (2 * part + bit * op_a) mod modulus
	// with part and op_a below the modulus the sum stays below three times it,
	// so one of the sum, sum - m or sum - 2m is the remainder
	logic [W+1:0] sum_w;
	logic [W+2:0] diff1_w;
	logic [W+2:0] diff2_w;
	logic [W-1:0] step_w;

	assign sum_w   = {1'b0, part_q, 1'b0} + {2'b00, (op_b_q[W-1] ? op_a_q : '0)};
	assign diff1_w = {1'b0, sum_w} - {3'b000, modulus_q};
	assign diff2_w = {1'b0, sum_w} - {2'b00, modulus_q, 1'b0};

	always_comb begin
		if (!diff2_w[W+2]) begin
			step_w = diff2_w[W-1:0];
		end else if (!diff1_w[W+2]) begin
			step_w = diff1_w[W-1:0];
		end else begin
			step_w = sum_w[W-1:0];
		end
	end

	logic pass_last;
	logic exp_last;
	logic out_free;
	logic [W-1:0] one_w;       // 1 mod modulus
	logic [W-1:0] final_w;     // result, forced to zero for a zero modulus

	assign pass_last = (cnt_q == CW'(OPERAND_WIDTH - 1));
	assign exp_last  = (ecnt_q == EW'(EXP_WIDTH - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign one_w     = (modulus_q == W'(1)) ? '0 : W'(1);
	assign final_w   = (modulus_q == '0) ? '0 : res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= W'(mexp_pkg::MODULUS_RESET);
			cnt_q       <= '0;
			ecnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (modulus_wen) begin
				modulus_q <= modulus_wdata;
			end

			// output register: a finished item loads it, the sink empties it
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_REDUCE;
						cnt_q   <= '0;
						ecnt_q  <= '0;
					end
				end
				ST_REDUCE, ST_MULT: begin
					if (pass_last) begin
						cnt_q <= '0;
						if (state_q == ST_REDUCE) begin
							// the reduce pass leads into the first square at bit zero
							state_q <= ST_SQUARE;
						end else if (exp_last) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SQUARE;
							ecnt_q  <= ecnt_q + EW'(1);
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_SQUARE: begin
					if (pass_last) begin
						cnt_q <= '0;
						if (exp_q[EXP_WIDTH-1]) begin
							state_q <= ST_MULT;
						end else if (exp_last) begin
							state_q <= ST_DONE;
						end else begin
							ecnt_q <= ecnt_q + EW'(1);
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			remainder_q <= final_w;
		end

		unique case (state_q)
			ST_IDLE: begin
				// reduce the base: part = 2 * part + bit, one base bit per cycle
				part_q <= '0;
				op_a_q <= W'(1);
				op_b_q <= base;
				exp_q  <= exponent;
			end
			ST_REDUCE: begin
				if (pass_last) begin
					base_q <= step_w;
					res_q  <= one_w;
					part_q <= '0;
					op_a_q <= one_w;
					op_b_q <= one_w;
				end else begin
					part_q <= step_w;
					op_b_q <= {op_b_q[W-2:0], 1'b0};
				end
			end
			ST_SQUARE: begin
				if (pass_last) begin
					res_q  <= step_w;
					part_q <= '0;
					if (exp_q[EXP_WIDTH-1]) begin
						op_a_q <= base_q;
						op_b_q <= step_w;
					end else begin
						op_a_q <= step_w;
						op_b_q <= step_w;
						exp_q  <= {exp_q[EXP_WIDTH-2:0], 1'b0};
					end
				end else begin
					part_q <= step_w;
					op_b_q <= {op_b_q[W-2:0], 1'b0};
				end
			end
			ST_MULT: begin
				if (pass_last) begin
					res_q  <= step_w;
					part_q <= '0;
					op_a_q <= step_w;
					op_b_q <= step_w;
					exp_q  <= {exp_q[EXP_WIDTH-2:0], 1'b0};
				end else begin
					part_q <= step_w;
					op_b_q <= {op_b_q[W-2:0], 1'b0};
				end
			end
			ST_DONE: begin
				part_q <= part_q;
			end
			default: begin
				part_q <= part_q;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign remainder = remainder_q;

endmodule
`default_nettype wire
